### src/unp_pkg.sv
// unp_pkg: payload types, internal float format and shared rounding helpers
// for the unit-normal packer. Depends on nothing; every other file uses it.
package unp_pkg;

  localparam logic [23:0] LEN_SCALE_M = 24'h8020C5; // significand of 1.001f, exponent 0
  localparam logic [31:0] POS_SAT = 32'h7fffffff;
  localparam logic [31:0] NEG_SAT = 32'h80000000;

  typedef struct packed {
    logic [31:0] vec_x_bits;
    logic [31:0] vec_y_bits;
    logic [31:0] vec_z_bits;
  } vec_bits_t;

  typedef struct packed {
    logic [31:0] packed_normal;
    logic        degenerate;
  } normal_t;

  // value = m * 2^(e-23), m[23] set unless zero or inf
  typedef struct packed {
    logic               zero;
    logic               inf;
    logic               sign;
    logic signed [10:0] e;
    logic [23:0]        m;
  } fp_t;

  typedef struct packed {
    fp_t x;
    fp_t y;
    fp_t z;
  } vec_t;

  typedef struct packed {
    logic               zero;
    logic               inf;
    logic signed [10:0] e;
    logic [47:0]        p;
  } prod_t;

  typedef struct packed {
    fp_t  sum;
    vec_t v;
    logic deg;
  } front_t;

  typedef struct packed {
    fp_t  len;
    vec_t v;
    logic deg;
  } len_t;

  typedef struct packed {
    logic en;
    logic load_r;
    logic load_s;
    logic r_from_s;
  } ctl_t;

  // Round-to-nearest-even into single precision, subnormal range included.
  // m[26] is the leading one, m[0] carries the sticky bit.
  function automatic fp_t fp_round(input logic sign, input logic signed [10:0] e,
                                   input logic [26:0] m);
    logic signed [11:0] d;
    logic [4:0]         dd;
    logic [28:0]        mm;
    logic [28:0]        lsb;
    logic [28:0]        half;
    logic [28:0]        res;
    logic               up;
    logic signed [10:0] er;
    fp_t                r;
    d = -12'sd126 - 12'(e);
    er = e;
    r.sign = sign;
    r.zero = 1'b0;
    r.inf = 1'b0;
    r.m = m[26:3];
    if (d > 12'sd24) begin
      r.zero = 1'b1;
    end else begin
      dd = (d < 12'sd0) ? 5'd0 : d[4:0];
      mm = {2'b00, m};
      lsb = 29'd8 << dd;
      half = 29'd4 << dd;
      up = (|(mm & half)) && ((|(mm & (half - 29'd1))) || (|(mm & lsb)));
      res = (mm & ~(lsb - 29'd1)) + (up ? lsb : 29'd0);
      if (res == 29'd0) begin
        r.zero = 1'b1;
      end else if (res[27]) begin
        r.m = res[27:4];
        er = e + 11'sd1;
      end else begin
        r.m = res[26:3];
      end
      if (!r.zero && er > 11'sd127) r.inf = 1'b1;
    end
    r.e = er;
    return r;
  endfunction

  function automatic prod_t fp_prod(input fp_t a, input logic [23:0] mb,
                                    input logic signed [10:0] eb);
    prod_t r;
    r.zero = a.zero;
    r.inf = a.inf;
    r.e = a.e + eb;
    r.p = a.m * mb;
    return r;
  endfunction

  function automatic fp_t fp_mul_round(input prod_t p);
    fp_t r;
    if (p.p[47]) r = fp_round(1'b0, p.e + 11'sd1, {p.p[47:22], |p.p[21:0]});
    else         r = fp_round(1'b0, p.e, {p.p[46:21], |p.p[20:0]});
    if (p.zero) begin
      r.zero = 1'b1;
      r.inf = 1'b0;
    end
    if (p.inf) begin
      r.inf = 1'b1;
      r.zero = 1'b0;
    end
    return r;
  endfunction

endpackage

### src/unp_ctl.sv
// unp_ctl: valid line of the datapath stages and the output register/skid control.
// Depends on unp_pkg (ctl_t).
module unp_ctl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output unp_pkg::ctl_t c
);

  localparam int STAGES = 39;

  logic [STAGES-1:0] valid;
  logic              s_valid;
  logic              take;

  assign take = out_valid && !out_stall;
  assign in_stall = s_valid;

  always_comb begin
    c.en = !s_valid;
    c.r_from_s = s_valid;
    c.load_r = s_valid ? take : (valid[STAGES-1] && (!out_valid || take));
    c.load_s = !s_valid && valid[STAGES-1] && out_valid && !take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      s_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!s_valid) begin
        valid <= {valid[STAGES-2:0], in_valid};
        if (!out_valid || take) out_valid <= valid[STAGES-1];
        if (c.load_s) s_valid <= 1'b1;
      end else if (take) begin
        s_valid <= 1'b0;
      end
    end
  end

endmodule

### src/unp_front.sv
// unp_front: unpack, squares and the two-step sum of squares (7 stages).
// Depends on unp_pkg (fp_t, fp_round, fp_prod, fp_mul_round).
module unp_front (
  input  logic               clk,
  input  logic               en,
  input  unp_pkg::vec_bits_t vec,
  output unp_pkg::front_t    f
);

  typedef struct packed {
    logic               zero;
    logic               inf;
    logic signed [10:0] e;
    logic [26:0]        bm;
    logic [26:0]        sm;
  } align_t;

  function automatic unp_pkg::fp_t fp_unpack(input logic [31:0] b);
    logic [4:0]   lz;
    logic [23:0]  fs;
    unp_pkg::fp_t r;
    lz = 5'd0;
    for (int i = 0; i < 23; i++) if (b[i]) lz = 5'(22 - i);
    fs = {b[22:0], 1'b0} << lz;
    r.sign = b[31];
    r.inf = (b[30:23] == 8'hff);
    r.zero = 1'b0;
    if (b[30:23] != 8'd0) begin
      r.m = {1'b1, b[22:0]};
      r.e = $signed({3'b000, b[30:23]}) - 11'sd127;
    end else if (b[22:0] == 23'd0) begin
      r.zero = 1'b1;
      r.m = 24'd0;
      r.e = 11'sd0;
    end else begin
      r.m = fs;
      r.e = -11'sd127 - $signed({6'b000000, lz});
    end
    return r;
  endfunction

  function automatic align_t fp_align(input unp_pkg::fp_t a, input unp_pkg::fp_t b);
    unp_pkg::fp_t       big;
    unp_pkg::fp_t       sml;
    logic signed [10:0] diff;
    logic [4:0]         dsh;
    logic [53:0]        w;
    align_t             r;
    if (a.zero || (!b.zero && b.e > a.e)) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    diff = big.e - sml.e;
    dsh = (diff > 11'sd27) ? 5'd27 : diff[4:0];
    w = {sml.m, 3'b000, 27'd0} >> dsh;
    r.zero = big.zero;
    r.inf = a.inf || b.inf;
    r.e = big.e;
    r.bm = {big.m, 3'b000};
    r.sm = sml.zero ? 27'd0 : (w[53:27] | {26'd0, |w[26:0]});
    return r;
  endfunction

  function automatic unp_pkg::fp_t fp_add_round(input align_t a);
    logic [27:0]  s;
    unp_pkg::fp_t r;
    s = {1'b0, a.bm} + {1'b0, a.sm};
    if (s[27]) r = unp_pkg::fp_round(1'b0, a.e + 11'sd1, {s[27:2], s[1] | s[0]});
    else       r = unp_pkg::fp_round(1'b0, a.e, s[26:0]);
    if (a.zero) begin
      r.zero = 1'b1;
      r.inf = 1'b0;
    end
    if (a.inf) begin
      r.inf = 1'b1;
      r.zero = 1'b0;
    end
    return r;
  endfunction

  unp_pkg::vec_t  v1, v2, v3, v4, v5, v6;
  logic           nf1, nf2, nf3, nf4, nf5, nf6;
  unp_pkg::prod_t px2, py2, pz2;
  unp_pkg::fp_t   sx3, sy3, sz3, sz4, sz5, sm5, sum7;
  align_t         al4, al6;

  assign sum7 = fp_add_round(al6);

  always_ff @(posedge clk) begin
    if (en) begin
      v1.x <= fp_unpack(vec.vec_x_bits);
      v1.y <= fp_unpack(vec.vec_y_bits);
      v1.z <= fp_unpack(vec.vec_z_bits);
      nf1 <= (&vec.vec_x_bits[30:23]) || (&vec.vec_y_bits[30:23]) ||
             (&vec.vec_z_bits[30:23]);

      px2 <= unp_pkg::fp_prod(v1.x, v1.x.m, v1.x.e);
      py2 <= unp_pkg::fp_prod(v1.y, v1.y.m, v1.y.e);
      pz2 <= unp_pkg::fp_prod(v1.z, v1.z.m, v1.z.e);
      v2 <= v1;
      nf2 <= nf1;

      sx3 <= unp_pkg::fp_mul_round(px2);
      sy3 <= unp_pkg::fp_mul_round(py2);
      sz3 <= unp_pkg::fp_mul_round(pz2);
      v3 <= v2;
      nf3 <= nf2;

      al4 <= fp_align(sx3, sy3);
      sz4 <= sz3;
      v4 <= v3;
      nf4 <= nf3;

      sm5 <= fp_add_round(al4);
      sz5 <= sz4;
      v5 <= v4;
      nf5 <= nf4;

      al6 <= fp_align(sm5, sz5);
      v6 <= v5;
      nf6 <= nf5;

      f.sum <= sum7;
      f.v <= v6;
      f.deg <= nf6 || sum7.zero;
    end
  end

endmodule

### src/unp_len.sv
// unp_len: correctly rounded square root (2 bits per stage) and the 1.001 scale.
// 17 stages. Depends on unp_pkg (fp_t, front_t, len_t, rounding helpers).
module unp_len (
  input  logic            clk,
  input  logic            en,
  input  unp_pkg::front_t f,
  output unp_pkg::len_t   lo
);

  localparam int SQRT_STEPS = 13;

  typedef struct packed {
    logic [27:0] rem;
    logic [25:0] root;
    logic [51:0] x;
  } sqrt_t;

  typedef struct packed {
    unp_pkg::vec_t      v;
    logic               deg;
    logic               zero;
    logic               inf;
    logic signed [10:0] e;
  } side_t;

  function automatic sqrt_t sqrt_iter(input sqrt_t s);
    logic [29:0] r2;
    logic [29:0] trial;
    sqrt_t       n;
    r2 = {s.rem, s.x[51:50]};
    trial = {2'b00, s.root, 2'b01};
    n.x = {s.x[49:0], 2'b00};
    if (r2 >= trial) begin
      n.rem = 28'(r2 - trial);
      n.root = {s.root[24:0], 1'b1};
    end else begin
      n.rem = r2[27:0];
      n.root = {s.root[24:0], 1'b0};
    end
    return n;
  endfunction

  sqrt_t          sq [0:SQRT_STEPS];
  side_t          sd [0:SQRT_STEPS];
  sqrt_t          sq_init;
  side_t          sd_init;
  unp_pkg::fp_t   rt, rt_next;
  unp_pkg::prod_t pr;
  unp_pkg::vec_t  v14, v15;
  logic           deg14, deg15;

  always_comb begin
    sq_init.rem = 28'd0;
    sq_init.root = 26'd0;
    sq_init.x = f.sum.e[0] ? {f.sum.m, 1'b0, 27'd0} : {1'b0, f.sum.m, 27'd0};
    sd_init.v = f.v;
    sd_init.deg = f.deg;
    sd_init.zero = f.sum.zero;
    sd_init.inf = f.sum.inf;
    sd_init.e = f.sum.e >>> 1;
  end

  always_comb begin
    rt_next = unp_pkg::fp_round(1'b0, sd[SQRT_STEPS].e,
                                {sq[SQRT_STEPS].root, |sq[SQRT_STEPS].rem});
    if (sd[SQRT_STEPS].zero) begin
      rt_next.zero = 1'b1;
      rt_next.inf = 1'b0;
    end
    if (sd[SQRT_STEPS].inf) begin
      rt_next.inf = 1'b1;
      rt_next.zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0] <= sq_init;
      sd[0] <= sd_init;
    end
  end

  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (en) begin
        sq[k] <= sqrt_iter(sqrt_iter(sq[k-1]));
        sd[k] <= sd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt <= rt_next;
      v14 <= sd[SQRT_STEPS].v;
      deg14 <= sd[SQRT_STEPS].deg;

      pr <= unp_pkg::fp_prod(rt, unp_pkg::LEN_SCALE_M, 11'sd0);
      v15 <= v14;
      deg15 <= deg14;

      lo.len <= unp_pkg::fp_mul_round(pr);
      lo.v <= v15;
      lo.deg <= deg15;
    end
  end

endmodule

### src/unp_div.sv
// unp_div: restoring significand divider, 2 quotient bits per stage, then rounding.
// 15 stages. Depends on unp_pkg (fp_t, fp_round).
module unp_div (
  input  logic         clk,
  input  logic         en,
  input  unp_pkg::fp_t num,
  input  unp_pkg::fp_t den,
  output unp_pkg::fp_t quo
);

  localparam int DIV_STEPS = 14;

  typedef struct packed {
    logic [25:0] rem;
    logic [27:0] q;
    logic [23:0] d;
  } div_t;

  typedef struct packed {
    logic               sign;
    logic               zero;
    logic signed [10:0] e;
  } side_t;

  function automatic div_t div_iter(input div_t s);
    div_t n;
    n.d = s.d;
    if (s.rem >= {2'b00, s.d}) begin
      n.rem = (s.rem - {2'b00, s.d}) << 1;
      n.q = {s.q[26:0], 1'b1};
    end else begin
      n.rem = s.rem << 1;
      n.q = {s.q[26:0], 1'b0};
    end
    return n;
  endfunction

  div_t         st [0:DIV_STEPS-1];
  side_t        sd [0:DIV_STEPS-1];
  div_t         st_init;
  unp_pkg::fp_t quo_next;
  logic         sticky;

  always_comb begin
    st_init.rem = {2'b00, num.m};
    st_init.q = 28'd0;
    st_init.d = den.m;
  end

  always_comb begin
    sticky = |st[DIV_STEPS-1].rem;
    if (st[DIV_STEPS-1].q[27]) begin
      quo_next = unp_pkg::fp_round(sd[DIV_STEPS-1].sign, sd[DIV_STEPS-1].e,
                                   {st[DIV_STEPS-1].q[27:2],
                                    (|st[DIV_STEPS-1].q[1:0]) | sticky});
    end else begin
      quo_next = unp_pkg::fp_round(sd[DIV_STEPS-1].sign, sd[DIV_STEPS-1].e - 11'sd1,
                                   {st[DIV_STEPS-1].q[26:1], st[DIV_STEPS-1].q[0] | sticky});
    end
    if (sd[DIV_STEPS-1].zero) begin
      quo_next.zero = 1'b1;
      quo_next.inf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_iter(div_iter(st_init));
      sd[0].sign <= num.sign ^ den.sign;
      sd[0].zero <= num.zero || num.inf || den.inf;
      sd[0].e <= num.e - den.e;
    end
  end

  for (genvar k = 1; k < DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= div_iter(div_iter(st[k-1]));
        sd[k] <= sd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) quo <= quo_next;
  end

endmodule

### src/unit_normal_pack_11_11_10_unit.sv
// unit_normal_pack_11_11_10_unit: single-precision normalize and 11:11:10 pack.
// Depends on unp_pkg, unp_ctl, unp_front, unp_len, unp_div.
//
//   channel   signals                         payload
//   vec       vec_valid / vec_stall           vec_bits_t    (x, y, z float bits)
//   normal    normal_valid / normal_stall     normal_t      (packed word, flag)
//
// One vector per cycle while vec_stall is low; 39 datapath stages plus the output register.
// The root (2 bits per stage) and the three dividers (2 bits per stage) set the depth.
// Reset clears the valid line and the valid flags of the output register and the skid stage.
// A stalled output fills the skid stage; only then is vec_stall raised and the
// whole datapath holds.
module unit_normal_pack_11_11_10_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               vec_valid,
  output logic               vec_stall,
  input  unp_pkg::vec_bits_t vec,
  output logic               normal_valid,
  input  logic               normal_stall,
  output unp_pkg::normal_t   normal
);

  localparam int DEG_DELAY = 15;

  unp_pkg::ctl_t          c;
  unp_pkg::front_t        fo;
  unp_pkg::len_t          lo;
  unp_pkg::fp_t           qx, qy, qz;
  logic [DEG_DELAY-1:0]   deg_line;
  logic [31:0]            tx, ty, tz;
  unp_pkg::normal_t       pk;
  unp_pkg::normal_t       skid;

  function automatic logic [31:0] fp_trunc(input unp_pkg::fp_t q);
    logic signed [10:0] s;
    logic [30:0]        mag;
    logic [31:0]        v;
    s = -11'sd1 - q.e;
    mag = 31'd0;
    if (q.zero) begin
      v = 32'd0;
    end else if (q.inf || !q.e[10]) begin
      v = q.sign ? unp_pkg::NEG_SAT : unp_pkg::POS_SAT;
    end else if (s > 11'sd30) begin
      v = 32'd0;
    end else begin
      mag = {q.m, 7'd0} >> s[4:0];
      v = q.sign ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
    end
    return v;
  endfunction

  unp_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vec_valid),
    .in_stall  (vec_stall),
    .out_valid (normal_valid),
    .out_stall (normal_stall),
    .c         (c)
  );

  unp_front u_front (
    .clk (clk),
    .en  (c.en),
    .vec (vec),
    .f   (fo)
  );

  unp_len u_len (
    .clk (clk),
    .en  (c.en),
    .f   (fo),
    .lo  (lo)
  );

  unp_div u_div_x (.clk(clk), .en(c.en), .num(lo.v.x), .den(lo.len), .quo(qx));
  unp_div u_div_y (.clk(clk), .en(c.en), .num(lo.v.y), .den(lo.len), .quo(qy));
  unp_div u_div_z (.clk(clk), .en(c.en), .num(lo.v.z), .den(lo.len), .quo(qz));

  always_comb begin
    tx = fp_trunc(qx);
    ty = fp_trunc(qy);
    tz = fp_trunc(qz);
    pk.degenerate = deg_line[DEG_DELAY-1];
    pk.packed_normal = deg_line[DEG_DELAY-1] ? 32'd0 : {tz[31:22], ty[31:21], tx[31:21]};
  end

  always_ff @(posedge clk) begin
    if (c.en) deg_line <= {deg_line[DEG_DELAY-2:0], lo.deg};
    if (c.load_s) skid <= pk;
    if (c.load_r) normal <= c.r_from_s ? skid : pk;
  end

endmodule

### verif/unp_checker.sv
// unp_checker: watches both channels of the unit-normal packer, predicts each
// packed normal bit-exactly in integer arithmetic and compares. Depends on unp_pkg.
module unp_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               vec_valid,
  input  logic               vec_stall,
  input  unp_pkg::vec_bits_t vec,
  input  logic               normal_valid,
  input  logic               normal_stall,
  input  unp_pkg::normal_t   normal,
  output int                 errors,
  output int                 pending,
  output int                 results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] LEN_GAIN = 32'h3F8020C5;

  unp_pkg::normal_t normal_due[$];

  function automatic void fp_split(input logic [31:0] b, output logic [127:0] m,
                                   output int e);
    if (b[30:23] == 8'd0) begin
      m = 128'(b[22:0]);
      e = -149;
    end else begin
      m = 128'({1'b1, b[22:0]});
      e = int'(b[30:23]) - 150;
    end
  endfunction

  // Round m * 2^e to nearest even in single precision.
  function automatic logic [31:0] fp_pack(input logic s, input logic [127:0] m,
                                          input int e);
    int p;
    int lsbe;
    int sh;
    logic [127:0] k;
    logic [127:0] remv;
    logic [127:0] half;
    if (m == 128'd0) return {s, 31'd0};
    p = 127;
    while (!m[p]) p--;
    lsbe = p + e - 23;
    if (lsbe < -149) lsbe = -149;
    sh = lsbe - e;
    if (sh <= 0) begin
      k = m << (-sh);
    end else if (sh > 126) begin
      k = 128'd0;
    end else begin
      k = m >> sh;
      remv = m & ((128'd1 << sh) - 128'd1);
      half = 128'd1 << (sh - 1);
      if (remv > half || (remv == half && k[0])) k = k + 128'd1;
    end
    if (k == (128'd1 << 24)) begin
      k = k >> 1;
      lsbe++;
    end
    if (k < (128'd1 << 23)) return {s, 8'd0, k[22:0]};
    if (lsbe + 150 >= 255) return {s, 8'hff, 23'd0};
    return {s, 8'(lsbe + 150), k[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    int ea;
    int eb;
    if (a[30:0] == 31'h7f800000 || b[30:0] == 31'h7f800000)
      return {a[31] ^ b[31], 31'h7f800000};
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    return fp_pack(a[31] ^ b[31], ma * mb, ea + eb);
  endfunction

  // Both operands non-negative.
  function automatic logic [31:0] fp_add_pos(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] t;
    int ea;
    int eb;
    int ti;
    if (a[30:23] == 8'hff || b[30:23] == 8'hff) return 32'h7f800000;
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    if (ma == 128'd0) return fp_pack(1'b0, mb, eb);
    if (mb == 128'd0) return fp_pack(1'b0, ma, ea);
    if (ea < eb) begin
      t = ma; ma = mb; mb = t;
      ti = ea; ea = eb; eb = ti;
    end
    if (ea - eb > 50) return fp_pack(1'b0, (ma << 50) | 128'd1, ea - 50);
    return fp_pack(1'b0, (ma << (ea - eb)) + mb, eb);
  endfunction

  function automatic logic [31:0] fp_sqrt(input logic [31:0] a);
    logic [127:0] m;
    logic [127:0] v;
    logic [127:0] r;
    logic [127:0] bt;
    int e;
    if (a[30:23] == 8'hff || a[30:0] == 31'd0) return a;
    fp_split(a, m, e);
    if (e % 2 != 0) begin
      m = m << 1;
      e = e - 1;
    end
    v = m << 60;
    r = 128'd0;
    bt = 128'd1 << 126;
    while (bt > v) bt = bt >> 2;
    while (bt != 128'd0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return fp_pack(1'b0, (r << 1) | 128'(v != 128'd0), (e - 60) / 2 - 1);
  endfunction

  // Divisor positive and finite.
  function automatic logic [31:0] fp_div(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] q;
    int ea;
    int eb;
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    if (ma == 128'd0) return {a[31], 31'd0};
    q = (ma << 60) / mb;
    return fp_pack(a[31], (q << 1) | 128'(((ma << 60) % mb) != 128'd0),
                   ea - eb - 61);
  endfunction

  // Truncate c * 2^31 toward zero to 32 bits, saturating.
  function automatic logic [31:0] fixed_q31(input logic [31:0] c);
    logic [127:0] m;
    logic [127:0] mag;
    int e;
    int k;
    fp_split(c, m, e);
    k = e + 31;
    if (k >= 64) mag = 128'd1 << 40;
    else if (k >= 0) mag = m << k;
    else if (-k >= 128) mag = 128'd0;
    else mag = m >> (-k);
    if (!c[31]) return (mag >= (128'd1 << 31)) ? unp_pkg::POS_SAT : mag[31:0];
    if (mag >= (128'd1 << 31)) return unp_pkg::NEG_SAT;
    return -mag[31:0];
  endfunction

  function automatic unp_pkg::normal_t predict_normal(input unp_pkg::vec_bits_t v);
    unp_pkg::normal_t r;
    logic [31:0] sum;
    logic [31:0] len;
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] tz;
    r = '0;
    if (&v.vec_x_bits[30:23] || &v.vec_y_bits[30:23] || &v.vec_z_bits[30:23]) begin
      r.degenerate = 1'b1;
      return r;
    end
    sum = fp_add_pos(fp_mul(v.vec_x_bits, v.vec_x_bits),
                     fp_mul(v.vec_y_bits, v.vec_y_bits));
    sum = fp_add_pos(sum, fp_mul(v.vec_z_bits, v.vec_z_bits));
    len = fp_mul(fp_sqrt(sum), LEN_GAIN);
    if (len[30:0] == 31'd0) begin
      r.degenerate = 1'b1;
      return r;
    end
    if (len[30:23] == 8'hff) return r;
    tx = fixed_q31(fp_div(v.vec_x_bits, len));
    ty = fixed_q31(fp_div(v.vec_y_bits, len));
    tz = fixed_q31(fp_div(v.vec_z_bits, len));
    r.packed_normal = {tz[31:22], ty[31:21], tx[31:21]};
    return r;
  endfunction

  always @(posedge clk) begin
    unp_pkg::normal_t want;
    if (rst) begin
      errors <= 0;
      results <= 0;
      pending <= 0;
      normal_due.delete();
    end else begin
      if (vec_valid && !vec_stall) normal_due.push_back(predict_normal(vec));
      if (normal_valid && !normal_stall) begin
        results <= results + 1;
        if (normal_due.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected transfer: %h/%b",
                                    normal.packed_normal, normal.degenerate);
        end else begin
          want = normal_due.pop_front();
          if (want.packed_normal !== normal.packed_normal ||
              want.degenerate !== normal.degenerate) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: expected %h/%b got %h/%b", want.packed_normal,
                       want.degenerate, normal.packed_normal, normal.degenerate);
          end
        end
      end
      pending <= normal_due.size();
    end
  end
endmodule

### verif/testbench.sv
// testbench: drives vectors into the unit-normal packer with bursty traffic and
// random output stalls; verdict from unp_checker. Depends on unp_pkg, the unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1100;

  logic               clk;
  logic               rst;
  logic               vec_valid;
  logic               vec_stall;
  unp_pkg::vec_bits_t vec;
  logic               normal_valid;
  logic               normal_stall = 1'b0;
  unp_pkg::normal_t   normal;
  int                 errors;
  int                 pending;
  int                 results;
  int                 stall_mode = 0;
  int                 cyc = 0;

  unit_normal_pack_11_11_10_unit uut (
    .clk(clk), .rst(rst), .vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
    .normal_valid(normal_valid), .normal_stall(normal_stall), .normal(normal)
  );

  unp_checker chk (
    .clk(clk), .rst(rst), .vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
    .normal_valid(normal_valid), .normal_stall(normal_stall), .normal(normal),
    .errors(errors), .pending(pending), .results(results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: normal_stall <= 1'b0;
      1: normal_stall <= ($urandom_range(0, 9) < 3);
      2: normal_stall <= ($urandom_range(0, 9) < 7);
      default: normal_stall <= (cyc % 16) < 5;
    endcase
  end

  function automatic logic [31:0] pick_comp(input int kind);
    case (kind)
      0: return 32'd0;
      1: return {$urandom_range(0, 1) == 1, 8'($urandom_range(110, 145)), 23'($urandom)};
      2: return $urandom;
      3: return {$urandom_range(0, 1) == 1, 8'($urandom_range(0, 30)), 23'($urandom)};
      4: return {$urandom_range(0, 1) == 1, 8'($urandom_range(190, 254)), 23'($urandom)};
      default: return {$urandom_range(0, 1) == 1, 8'hff, 23'($urandom_range(0, 1))};
    endcase
  endfunction

  function automatic unp_pkg::vec_bits_t random_vec();
    unp_pkg::vec_bits_t v;
    int mode;
    mode = $urandom_range(0, 19);
    if (mode < 12) begin
      v.vec_x_bits = pick_comp(($urandom_range(0, 9) == 0) ? 0 : 1);
      v.vec_y_bits = pick_comp(($urandom_range(0, 9) == 0) ? 0 : 1);
      v.vec_z_bits = pick_comp(($urandom_range(0, 9) == 0) ? 0 : 1);
    end else if (mode < 14) begin
      v = {$urandom, $urandom, $urandom};
    end else if (mode < 16) begin
      v = {pick_comp(3), pick_comp(3), pick_comp(3)};
    end else if (mode < 18) begin
      v = {pick_comp(4), pick_comp(4), pick_comp(1)};
    end else begin
      v = {pick_comp($urandom_range(0, 5)), pick_comp($urandom_range(0, 5)),
           pick_comp($urandom_range(0, 5))};
    end
    return v;
  endfunction

  task automatic send_vec(input unp_pkg::vec_bits_t v);
    vec <= v;
    vec_valid <= 1'b1;
    do @(posedge clk); while (vec_stall);
  endtask

  task automatic pause_sender();
    int n;
    n = $urandom_range(1, 8);
    vec_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    unp_pkg::vec_bits_t dir[$];
    int burst;
    int wait_cyc;
    rst = 1'b1;
    vec_valid = 1'b0;
    vec = '0;
    dir = '{
      '{32'h00000000, 32'h00000000, 32'h00000000},
      '{32'h80000000, 32'h00000000, 32'h80000000},
      '{32'h3f800000, 32'h00000000, 32'h00000000},
      '{32'hbf800000, 32'h00000000, 32'h00000000},
      '{32'h00000000, 32'h3f800000, 32'h00000000},
      '{32'h00000000, 32'hbf800000, 32'h00000000},
      '{32'h00000000, 32'h00000000, 32'h3f800000},
      '{32'h00000000, 32'h00000000, 32'hbf800000},
      '{32'h3f800000, 32'h3f800000, 32'h3f800000},
      '{32'hbf800000, 32'hbf800000, 32'hbf800000},
      '{32'h7f800000, 32'h3f800000, 32'h00000000},
      '{32'h00000000, 32'hff800000, 32'h00000000},
      '{32'h00000000, 32'h00000000, 32'h7fc00000},
      '{32'hffffffff, 32'h3f800000, 32'h3f800000},
      '{32'h7f7fffff, 32'h7f7fffff, 32'h7f7fffff},
      '{32'hff7fffff, 32'h00000000, 32'h00000000},
      '{32'h00000001, 32'h00000000, 32'h00000000},
      '{32'h80000001, 32'h00000001, 32'h00000001},
      '{32'h007fffff, 32'h807fffff, 32'h00000000},
      '{32'h00000000, 32'h00000000, 32'h00800000},
      '{32'h1f800000, 32'h00000000, 32'h00000000},
      '{32'h00000000, 32'h1a000000, 32'h9a000000},
      '{32'h5f800000, 32'hdf800000, 32'h5f800000},
      '{32'h7fffffff, 32'h7f800001, 32'hff800001}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (dir[i]) send_vec(dir[i]);
    pause_sender();
    burst = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (burst == 0) begin
        if (i > 0) pause_sender();
        burst = $urandom_range(1, 40);
      end
      send_vec(random_vec());
      burst--;
    end
    vec_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    wait_cyc = 0;
    while (wait_cyc < 60) begin
      @(posedge clk);
      wait_cyc++;
    end
    $display("Sent %0d directed and %0d random vectors; %0d results checked.",
             dir.size(), N_RANDOM, results);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
